// File: rtl/xalu_pkg.sv
// ----------------------------------------------------------------------------
// xalu_pkg
// shared types, request codes and width helpers for the x86 integer alu
// ----------------------------------------------------------------------------
`default_nettype none
package xalu_pkg;

  localparam int DEF_MAX_WIDTH = 32;
  localparam int DATA_W = 32;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_CMP  = 4'd2;
  localparam logic [3:0] OP_INC  = 4'd3;
  localparam logic [3:0] OP_DEC  = 4'd4;
  localparam logic [3:0] OP_ADC  = 4'd5;
  localparam logic [3:0] OP_SBB  = 4'd6;
  localparam logic [3:0] OP_MUL  = 4'd7;
  localparam logic [3:0] OP_IMULW = 4'd8;
  localparam logic [3:0] OP_IMULT = 4'd9;
  localparam logic [3:0] OP_DIV  = 4'd10;
  localparam logic [3:0] OP_IDIV = 4'd11;

  localparam logic [1:0] WC_BYTE  = 2'd0;
  localparam logic [1:0] WC_WORD  = 2'd1;

  // classified item as handed from front to back
  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  wsel;      // 0 byte, 1 word, 2 dword (after clamp)
    logic [31:0] a;         // dest at width
    logic [31:0] b;         // source / multiplier at width
    logic [63:0] n;         // dividend
  } xalu_item_t;

endpackage
`default_nettype wire

// File: rtl/x86_integer_alu_with_flags.sv
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags
// x86 integer alu with stored cf, of, zf and sf flags
// ----------------------------------------------------------------------------
// A front end accepts a request transaction, masks the operands to the chosen
// width and places it in a two-entry queue. The back end takes one item at a
// time: add, sub, cmp, inc, dec, adc and sbb are computed combinationally on the
// queue head and registered into the output as the item is taken, so such a
// result passes through the queue slot and the output register; a new one can
// follow every cycle while the output is drained and no multiply or divide is
// running. Multiplies run a shift-add loop of one bit per cycle and divides a
// restoring loop of one quotient bit per cycle (a zero divisor or certain
// quotient overflow skips the loop). During those the queue fills and the input
// stalls. Flags update only on the add and subtract forms; inc and dec keep cf.
// A divide error returns zero results, no write back, and leaves the flags alone.
`default_nettype none
module x86_integer_alu_with_flags
  import xalu_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  req_type,
  input  wire logic [1:0]  width_code,
  input  wire logic [31:0] dest_value,
  input  wire logic [31:0] src_value,
  input  wire logic [31:0] acc_low,
  input  wire logic [31:0] acc_high,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_low,
  output logic [31:0]      result_high,
  output logic             writes_dest,
  output logic             carry_out,
  output logic             overflow_out,
  output logic             zero_out,
  output logic             sign_out,
  output logic             divide_error
);

  // queue between front and back
  logic       q_valid, q_ready;
  xalu_item_t q_item;

  xalu_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .width_code, .dest_value,
    .src_value, .acc_low, .acc_high, .q_valid, .q_ready, .q_item
  );

  // execution and flag state
  xalu_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .out_valid, .out_ready,
    .result_low, .result_high, .writes_dest, .carry_out, .overflow_out,
    .zero_out, .sign_out, .divide_error
  );

endmodule
`default_nettype wire

// File: rtl/xalu_front.sv
// ----------------------------------------------------------------------------
// xalu_front
// accepts requests, masks operands to width and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none
module xalu_front
  import xalu_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  req_type,
  input  wire logic [1:0]  width_code,
  input  wire logic [31:0] dest_value,
  input  wire logic [31:0] src_value,
  input  wire logic [31:0] acc_low,
  input  wire logic [31:0] acc_high,
  output logic             q_valid,
  input  wire logic        q_ready,
  output xalu_item_t       q_item
);

  localparam logic [1:0] MAX_SEL = (MAX_WIDTH > 16) ? 2'd2 : ((MAX_WIDTH > 8) ? 2'd1 : 2'd0);

  xalu_item_t item;
  logic [1:0] wsel;
  logic [31:0] mask;
  xalu_item_t slot [2];
  logic [1:0] cnt;
  logic wp, rp;

  always_comb begin
    wsel = (width_code > 2'd2) ? 2'd2 : width_code;
    if (wsel > MAX_SEL) wsel = MAX_SEL;
    case (wsel)
      WC_BYTE: mask = 32'h0000_00ff;
      WC_WORD: mask = 32'h0000_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    item.op   = req_type;
    item.wsel = wsel;
    item.a    = dest_value & mask;
    item.b    = ((req_type == OP_MUL) || (req_type == OP_IMULW)) ? (acc_low & mask)
              : (src_value & mask);
    case (wsel)
      WC_BYTE: item.n = {48'd0, acc_low[15:0]};
      WC_WORD: item.n = {32'd0, acc_high[15:0], acc_low[15:0]};
      default: item.n = {acc_high, acc_low};
    endcase
  end

  // two-entry queue
  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = slot[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slot[wp] <= item;
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'((in_valid && in_ready) ? 1 : 0) - 2'((q_valid && q_ready) ? 1 : 0);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count out of range");
  a_ptr_cnt: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd1) |-> (wp != rp))
    else $error("queue pointers disagree with count");
  a_full_ptr: assert property (@(posedge clk) disable iff (rst)
    ((cnt == 2'd0) || (cnt == 2'd2)) |-> (wp == rp))
    else $error("queue pointers disagree with empty or full");

endmodule
`default_nettype wire

// File: rtl/xalu_back.sv
// ----------------------------------------------------------------------------
// xalu_back
// executes queued items: add forms straight from the queue head, bit-serial mul and div
// ----------------------------------------------------------------------------
`default_nettype none
module xalu_back
  import xalu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  xalu_item_t       q_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_low,
  output logic [31:0]      result_high,
  output logic             writes_dest,
  output logic             carry_out,
  output logic             overflow_out,
  output logic             zero_out,
  output logic             sign_out,
  output logic             divide_error
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state;
  logic cf, of, zf, sf;

  // working item
  logic [3:0]  op;
  logic [1:0]  wsel;
  logic [5:0]  w;          // 8, 16 or 32
  logic [5:0]  cnt;
  logic [32:0] acc;        // product high / partial remainder
  logic [63:0] sh;         // multiplier / dividend shift register
  logic [31:0] mb;         // multiplicand or divisor magnitude
  logic        nneg, rneg;
  logic        err_pre;

  logic out_full;
  wire take = q_valid && q_ready;
  // mul and div go through the iterative loop and fill the output later
  wire iter_op = (q_item.op == OP_MUL) || (q_item.op == OP_IMULW) || (q_item.op == OP_IMULT)
              || (q_item.op == OP_DIV) || (q_item.op == OP_IDIV);
  wire fill = (take && !iter_op) || ((state == ST_FIN) && (!out_full || out_ready));
  assign q_ready = (state == ST_IDLE) && !(out_full && !out_ready);
  assign out_valid = out_full;

  // combinational add and subtract path on the queue head
  logic [31:0] mask, sbit, a, b, r;
  logic [32:0] s;
  logic addf, subf, c_new, o_new;
  always_comb begin
    case (q_item.wsel)
      WC_BYTE: begin mask = 32'hff; sbit = 32'h80; end
      WC_WORD: begin mask = 32'hffff; sbit = 32'h8000; end
      default: begin mask = 32'hffff_ffff; sbit = 32'h8000_0000; end
    endcase
    a = q_item.a;
    b = ((q_item.op == OP_INC) || (q_item.op == OP_DEC)) ? 32'd1 : q_item.b;
    addf = (q_item.op == OP_ADD) || (q_item.op == OP_INC) || (q_item.op == OP_ADC);
    subf = (q_item.op == OP_SUB) || (q_item.op == OP_CMP) || (q_item.op == OP_DEC)
        || (q_item.op == OP_SBB);
    if (addf) s = {1'b0, a} + {1'b0, b} + 33'((q_item.op == OP_ADC) ? cf : 1'b0);
    else      s = {1'b0, a} - {1'b0, b} - 33'((q_item.op == OP_SBB) ? cf : 1'b0);
    r = s[31:0] & mask;
    case (q_item.wsel)
      WC_BYTE: c_new = s[8];
      WC_WORD: c_new = s[16];
      default: c_new = s[32];
    endcase
    if (addf) o_new = |((~(a ^ b)) & (a ^ r) & sbit);
    else      o_new = |((a ^ b) & (a ^ r) & sbit);
  end

  // ---- divide step ----
  logic [32:0] trial;
  logic [32:0] rem_sh;
  always_comb begin
    rem_sh = {acc[31:0], sh[63]};
    trial  = rem_sh - {1'b0, mb};
  end

  // magnitudes at issue
  logic [31:0] wmask, wsb;
  logic [63:0] nmag;
  logic [31:0] amag, bmag, nhi;
  logic sa, sb, sn;
  always_comb begin
    wmask = mask; wsb = sbit;
    sa = |(q_item.a & wsb);
    sb = |(q_item.b & wsb);
    case (q_item.wsel)
      WC_BYTE: sn = q_item.n[15];
      WC_WORD: sn = q_item.n[31];
      default: sn = q_item.n[63];
    endcase
    amag = (sa ? (32'd0 - q_item.a) : q_item.a) & wmask;
    bmag = (sb ? (32'd0 - q_item.b) : q_item.b) & wmask;
    if (q_item.op == OP_IDIV && sn) begin
      case (q_item.wsel)
        WC_BYTE: nmag = {48'd0, 16'(16'd0 - q_item.n[15:0])};
        WC_WORD: nmag = {32'd0, 32'(32'd0 - q_item.n[31:0])};
        default: nmag = 64'd0 - q_item.n;
      endcase
    end else begin
      nmag = q_item.n;
    end
    // high half of the dividend, the starting partial remainder
    case (q_item.wsel)
      WC_BYTE: nhi = {24'd0, nmag[15:8]};
      WC_WORD: nhi = {16'd0, nmag[31:16]};
      default: nhi = nmag[63:32];
    endcase
  end

  // finish-time values
  logic [31:0] q_fin, r_fin, fmask, fsb, lo_fin, hi_fin;
  logic [63:0] prod, sprod;
  logic [31:0] limit;
  logic ovf;
  always_comb begin
    case (wsel)
      WC_BYTE: begin fmask = 32'hff; fsb = 32'h80; end
      WC_WORD: begin fmask = 32'hffff; fsb = 32'h8000; end
      default: begin fmask = 32'hffff_ffff; fsb = 32'h8000_0000; end
    endcase
    q_fin = sh[31:0] & fmask;
    r_fin = acc[31:0] & fmask;
    limit = fsb;
    ovf = 1'b0;
    if (op == OP_IDIV) ovf = rneg ? (q_fin > limit) : (q_fin >= limit);
    prod = {acc[31:0], sh[63:32]} >> (6'd32 - w);
    sprod = rneg ? (64'd0 - prod) : prod;
    lo_fin = 32'd0; hi_fin = 32'd0;
    if (op == OP_DIV || op == OP_IDIV) begin
      lo_fin = ((op == OP_IDIV && rneg) ? (32'd0 - q_fin) : q_fin) & fmask;
      hi_fin = ((op == OP_IDIV && nneg) ? (32'd0 - r_fin) : r_fin) & fmask;
    end else begin
      lo_fin = sprod[31:0] & fmask;
      case (wsel)
        WC_BYTE: hi_fin = {24'd0, sprod[15:8]};
        WC_WORD: hi_fin = {16'd0, sprod[31:16]};
        default: hi_fin = sprod[63:32];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_full <= 1'b0;
      cf <= 1'b0; of <= 1'b0; zf <= 1'b0; sf <= 1'b0;
    end else begin
      out_full <= fill || (out_full && !out_ready);
      case (state)
        ST_IDLE: if (take) begin
          op <= q_item.op;
          wsel <= q_item.wsel;
          w <= (q_item.wsel == WC_BYTE) ? 6'd8 : ((q_item.wsel == WC_WORD) ? 6'd16 : 6'd32);
          cnt <= 6'd0;
          if (addf || subf) begin
            result_low <= r;
            result_high <= 32'd0;
            writes_dest <= (q_item.op != OP_CMP);
            divide_error <= 1'b0;
            if (!(q_item.op == OP_INC || q_item.op == OP_DEC)) cf <= c_new;
            of <= o_new; zf <= (r == 32'd0); sf <= |(r & sbit);
            carry_out <= (q_item.op == OP_INC || q_item.op == OP_DEC) ? cf : c_new;
            overflow_out <= o_new; zero_out <= (r == 32'd0); sign_out <= |(r & sbit);
          end else if (q_item.op == OP_MUL || q_item.op == OP_IMULW
                       || q_item.op == OP_IMULT) begin
            acc <= 33'd0;
            if (q_item.op == OP_MUL) begin
              mb <= q_item.a; sh <= {q_item.b, 32'd0}; rneg <= 1'b0;
            end else begin
              mb <= amag; sh <= {bmag, 32'd0}; rneg <= sa ^ sb;
            end
            state <= ST_MUL;
          end else if (q_item.op == OP_DIV || q_item.op == OP_IDIV) begin
            mb <= (q_item.op == OP_IDIV) ? amag : q_item.a;
            nneg <= (q_item.op == OP_IDIV) && sn;
            rneg <= (q_item.op == OP_IDIV) && (sn ^ sa);
            err_pre <= (q_item.a == 32'd0)
                    || (((q_item.op == OP_IDIV) ? nhi : q_item.n[63:32] & 32'd0
                        | nhi) >= ((q_item.op == OP_IDIV) ? amag : q_item.a));
            case (q_item.wsel)
              WC_BYTE: sh <= {nmag[7:0], 56'd0};
              WC_WORD: sh <= {nmag[15:0], 48'd0};
              default: sh <= {nmag[31:0], 32'd0};
            endcase
            acc <= {1'b0, nhi};
            state <= ST_DIV;
          end else begin
            result_low <= 32'd0; result_high <= 32'd0;
            writes_dest <= 1'b0; divide_error <= 1'b0;
            carry_out <= cf; overflow_out <= of; zero_out <= zf; sign_out <= sf;
          end
        end
        ST_MUL: begin
          // shift-add on the multiplier bits, lsb first, w steps
          logic [32:0] sum;
          sum = acc + (sh[32] ? {1'b0, mb} : 33'd0);
          sh <= {sum[0], sh[63:33], 32'd0};
          acc <= {1'b0, sum[32:1]};
          cnt <= cnt + 6'd1;
          if (cnt + 6'd1 == w) state <= ST_FIN;
        end
        ST_DIV: begin
          if (err_pre) begin
            state <= ST_FIN;
          end else begin
            if (!trial[32]) begin
              acc <= trial;
              sh <= {sh[62:0], 1'b1};
            end else begin
              acc <= rem_sh;
              sh <= {sh[62:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
            if (cnt + 6'd1 == w) state <= ST_FIN;
          end
        end
        default: begin
          if (!out_full || out_ready) begin
            state <= ST_IDLE;
            carry_out <= cf; overflow_out <= of; zero_out <= zf; sign_out <= sf;
            if ((op == OP_DIV || op == OP_IDIV) && (err_pre || ovf)) begin
              result_low <= 32'd0; result_high <= 32'd0;
              writes_dest <= 1'b0; divide_error <= 1'b1;
            end else begin
              result_low <= lo_fin; result_high <= hi_fin;
              writes_dest <= 1'b1; divide_error <= 1'b0;
            end
          end
        end
      endcase
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !q_ready)
    else $error("queue popped while busy");
  a_err_nowrite: assert property (@(posedge clk) disable iff (rst)
    (out_full && divide_error) |-> !writes_dest)
    else $error("divide error with write back");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL || state == ST_DIV) |-> (cnt < w))
    else $error("iteration count past width");

endmodule
`default_nettype wire
